@@ design/palette_fade_interpolator_core_macros.svh @@
// ----------------------------------------------------------------------------
// Palette fade interpolator assertion macros
// Concurrent check helpers clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PALETTE_FADE_INTERPOLATOR_CORE_MACROS_SVH
`define PALETTE_FADE_INTERPOLATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PFI_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("palette fade check failed");

// next-cycle implication
`define PFI_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("palette fade check failed");

`else

`define PFI_ASSERT_IMP(label, ante, cons)
`define PFI_ASSERT_NXT(label, ante, cons)

`endif

`endif

@@ design/pfi_pkg.sv @@
// ----------------------------------------------------------------------------
// Palette fade interpolator package
// Shared widths, codes and the request/response bundles of the divider.
// ----------------------------------------------------------------------------
package pfi_pkg;

	localparam int COLOR_W   = 8;
	localparam int STEP_W    = 8;
	// magnitude of count * (target - start) fits 16 bits (255 * 255)
	localparam int PROD_W    = 16;
	localparam int DIV_CNT_W = $clog2(PROD_W);
	localparam int NUM_CH    = 3;
	localparam int CH_W      = $clog2(NUM_CH);

	localparam logic [STEP_W-1:0] STEPS_RESET = STEP_W'(32);
	localparam logic [STEP_W-1:0] STEP_MAX    = {STEP_W{1'b1}};

	typedef enum logic [1:0] {
		OP_CONTINUE = 2'd0,
		OP_BEGIN    = 2'd1,
		OP_STOP     = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [STEP_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quotient;
	} div_rsp_t;

endpackage

@@ design/pfi_div.sv @@
// ----------------------------------------------------------------------------
// Palette fade shared divider
// Unsigned restoring divider, one quotient bit per cycle, nonzero divisor.
// ----------------------------------------------------------------------------
module pfi_div (
	input  logic               clk,
	input  logic               arst_n,
	input  pfi_pkg::div_req_t  req,
	output pfi_pkg::div_rsp_t  rsp
);

	logic                           busy_q;
	logic                           done_q;
	logic [pfi_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [pfi_pkg::STEP_W-1:0]     rem_q;
	logic [pfi_pkg::STEP_W-1:0]     dsr_q;
	logic [pfi_pkg::PROD_W-1:0]     quo_q;

	logic [pfi_pkg::STEP_W:0]       trial;
	logic [pfi_pkg::STEP_W:0]       diff;
	logic                           fits;
	logic [pfi_pkg::STEP_W-1:0]     rem_nxt;

	// one trial subtraction per cycle
	always_comb begin
		trial   = {rem_q, quo_q[pfi_pkg::PROD_W-1]};
		diff    = trial - {1'b0, dsr_q};
		fits    = (trial >= {1'b0, dsr_q});
		rem_nxt = fits ? diff[pfi_pkg::STEP_W-1:0] : trial[pfi_pkg::STEP_W-1:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pfi_pkg::DIV_CNT_W'(pfi_pkg::PROD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	// datapath: dividend shifts out as quotient shifts in
	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[pfi_pkg::PROD_W-2:0], fits};
		end else if (req.start) begin
			rem_q <= '0;
			dsr_q <= req.divisor;
			quo_q <= req.dividend;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ design/palette_fade_interpolator_core.sv @@
// ----------------------------------------------------------------------------
// Palette fade interpolator core
// Linear fade of one palette entry per item: count*(to-from)/steps + from.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid / in_stall) takes one palette entry word: opcode,
//  start color, target color and the to_black flag. in_stall is high while
//  an entry is being worked on.
//  Output channel (out_valid / out_stall) returns one word per entry: the
//  interpolated color, the step count and the fade running flag.
//  Configuration channel (cfg_valid / cfg_ready / cfg_data) writes the fade
//  step total; cfg_ready is always high. A total of zero acts as one.
//  Sequencing: the three channels share one 16-step restoring divider. Each
//  channel goes through the product, then sixteen quotient bits and the
//  hand-back; after the last channel the result is loaded into the output
//  register, and only then is the next entry taken.
//  A finished result waits in the output register while out_stall is high;
//  the next entry is already accepted and worked on meanwhile, and only its
//  final load waits for the register to free up.
//  Reset clears the step counter, the fade flag and all valids, and sets the
//  step total to 32.
// ----------------------------------------------------------------------------
`include "palette_fade_interpolator_core_macros.svh"

module palette_fade_interpolator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pfi_pkg::STEP_W-1:0]    cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    opcode,
	input  logic [pfi_pkg::COLOR_W-1:0]   from_red,
	input  logic [pfi_pkg::COLOR_W-1:0]   from_green,
	input  logic [pfi_pkg::COLOR_W-1:0]   from_blue,
	input  logic [pfi_pkg::COLOR_W-1:0]   to_red,
	input  logic [pfi_pkg::COLOR_W-1:0]   to_green,
	input  logic [pfi_pkg::COLOR_W-1:0]   to_blue,
	input  logic                          to_black,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pfi_pkg::COLOR_W-1:0]   out_red,
	output logic [pfi_pkg::COLOR_W-1:0]   out_green,
	output logic [pfi_pkg::COLOR_W-1:0]   out_blue,
	output logic [pfi_pkg::STEP_W-1:0]    step_number,
	output logic                          fade_running
);

	pfi_pkg::state_t                state_q, state_nxt;
	logic [pfi_pkg::STEP_W-1:0]     total_q;
	logic [pfi_pkg::STEP_W-1:0]     steps_eff;
	logic [pfi_pkg::STEP_W-1:0]     step_q, step_nxt;
	logic                           active_q, active_nxt;
	logic [pfi_pkg::STEP_W-1:0]     step_inc;
	logic [pfi_pkg::CH_W-1:0]       ch_q;
	logic [pfi_pkg::COLOR_W-1:0]    from_q [pfi_pkg::NUM_CH];
	logic [pfi_pkg::COLOR_W-1:0]    to_q   [pfi_pkg::NUM_CH];
	logic [pfi_pkg::COLOR_W-1:0]    res_q  [pfi_pkg::NUM_CH];
	logic                           neg_q;
	logic                           out_valid_q;
	logic [pfi_pkg::COLOR_W-1:0]    out_red_q, out_green_q, out_blue_q;
	logic [pfi_pkg::STEP_W-1:0]     out_step_q;
	logic                           out_run_q;

	logic                           in_acc;
	logic                           out_free;
	logic                           div_start;
	logic                           ch_last;
	logic                           load_out;
	logic signed [pfi_pkg::COLOR_W:0]      diff;
	logic signed [2*pfi_pkg::COLOR_W+1:0]  prod;
	logic        [2*pfi_pkg::COLOR_W+1:0]  prod_abs;
	logic [pfi_pkg::COLOR_W-1:0]    quo_lo;
	logic [pfi_pkg::COLOR_W-1:0]    res_ch;
	pfi_pkg::div_req_t              div_req;
	pfi_pkg::div_rsp_t              div_rsp;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= pfi_pkg::STEPS_RESET;
		end else if (cfg_valid) begin
			total_q <= cfg_data;
		end
	end

	assign steps_eff = (total_q == '0) ? pfi_pkg::STEP_W'(1) : total_q;

	// fade state update for an accepted entry
	always_comb begin
		step_inc   = (step_q == pfi_pkg::STEP_MAX) ? step_q : step_q + 1'b1;
		step_nxt   = step_q;
		active_nxt = active_q;
		unique case (pfi_pkg::opcode_t'(opcode))
			pfi_pkg::OP_BEGIN: begin
				if (active_q) begin
					step_nxt   = step_inc;
					active_nxt = (step_inc < steps_eff);
				end else begin
					step_nxt   = '0;
					active_nxt = 1'b1;
				end
			end
			pfi_pkg::OP_STOP: begin
				active_nxt = 1'b0;
			end
			default: begin
				step_nxt   = step_q;
				active_nxt = active_q;
			end
		endcase
	end

	// signed product of count and channel difference, then its magnitude
	always_comb begin
		diff     = $signed({1'b0, to_q[ch_q]}) - $signed({1'b0, from_q[ch_q]});
		prod     = $signed({1'b0, step_q}) * diff;
		prod_abs = prod[2*pfi_pkg::COLOR_W+1] ? 18'(-prod) : 18'(prod);
	end

	// truncating quotient applied back to the start color, low bits kept
	assign quo_lo = div_rsp.quotient[pfi_pkg::COLOR_W-1:0];
	assign res_ch = neg_q ? (from_q[ch_q] - quo_lo) : (from_q[ch_q] + quo_lo);

	assign div_req.start    = div_start;
	assign div_req.dividend = prod_abs[pfi_pkg::PROD_W-1:0];
	assign div_req.divisor  = steps_eff;

	pfi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign ch_last  = (ch_q == pfi_pkg::CH_W'(pfi_pkg::NUM_CH - 1));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfi_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_stall  = 1'b1;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			pfi_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_nxt = pfi_pkg::ST_MUL;
				end
			end
			pfi_pkg::ST_MUL: begin
				div_start = 1'b1;
				state_nxt = pfi_pkg::ST_DIV;
			end
			pfi_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_nxt = ch_last ? pfi_pkg::ST_OUT : pfi_pkg::ST_MUL;
				end
			end
			pfi_pkg::ST_OUT: begin
				if (out_free) begin
					load_out  = 1'b1;
					state_nxt = pfi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = pfi_pkg::ST_IDLE;
			end
		endcase
	end

	// fade state and channel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			active_q <= 1'b0;
			ch_q     <= '0;
		end else begin
			if (in_acc) begin
				step_q   <= step_nxt;
				active_q <= active_nxt;
				ch_q     <= '0;
			end else if (state_q == pfi_pkg::ST_DIV && div_rsp.done && !ch_last) begin
				ch_q <= ch_q + 1'b1;
			end
		end
	end

	// entry colors, per-channel sign and results
	always_ff @(posedge clk) begin
		if (in_acc) begin
			from_q[0] <= from_red;
			from_q[1] <= from_green;
			from_q[2] <= from_blue;
			to_q[0]   <= to_black ? '0 : to_red;
			to_q[1]   <= to_black ? '0 : to_green;
			to_q[2]   <= to_black ? '0 : to_blue;
		end
		if (div_start) begin
			neg_q <= prod[2*pfi_pkg::COLOR_W+1];
		end
		if (state_q == pfi_pkg::ST_DIV && div_rsp.done) begin
			res_q[ch_q] <= res_ch;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_red_q   <= res_q[0];
			out_green_q <= res_q[1];
			out_blue_q  <= res_q[2];
			out_step_q  <= step_q;
			out_run_q   <= active_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_red      = out_red_q;
	assign out_green    = out_green_q;
	assign out_blue     = out_blue_q;
	assign step_number  = out_step_q;
	assign fade_running = out_run_q;

	// checks
	`PFI_ASSERT_IMP(a_div_done_in_div, div_rsp.done, state_q == pfi_pkg::ST_DIV)
	`PFI_ASSERT_IMP(a_out_from_seq, $rose(out_valid_q), $past(state_q) == pfi_pkg::ST_OUT)
	`PFI_ASSERT_NXT(a_acc_starts_mul, in_acc, state_q == pfi_pkg::ST_MUL && ch_q == '0)

endmodule

@@ test/palette_fade_interpolator_core_checker.sv @@
// ----------------------------------------------------------------------------
// Palette fade interpolator checker
// Watches the config, input and output channels of the fade core, keeps its
// own copy of the step total, step count and fade flag, predicts one output
// word per accepted input word and compares it with what the core returns.
// ----------------------------------------------------------------------------
module palette_fade_interpolator_core_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [pfi_pkg::STEP_W-1:0]    cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [1:0]                    opcode,
	input  logic [pfi_pkg::COLOR_W-1:0]   from_red,
	input  logic [pfi_pkg::COLOR_W-1:0]   from_green,
	input  logic [pfi_pkg::COLOR_W-1:0]   from_blue,
	input  logic [pfi_pkg::COLOR_W-1:0]   to_red,
	input  logic [pfi_pkg::COLOR_W-1:0]   to_green,
	input  logic [pfi_pkg::COLOR_W-1:0]   to_blue,
	input  logic                          to_black,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [pfi_pkg::COLOR_W-1:0]   out_red,
	input  logic [pfi_pkg::COLOR_W-1:0]   out_green,
	input  logic [pfi_pkg::COLOR_W-1:0]   out_blue,
	input  logic [pfi_pkg::STEP_W-1:0]    step_number,
	input  logic                          fade_running,
	output int                            error_count,
	output int                            pending
);

	typedef struct packed {
		logic [pfi_pkg::COLOR_W-1:0] red;
		logic [pfi_pkg::COLOR_W-1:0] green;
		logic [pfi_pkg::COLOR_W-1:0] blue;
		logic [pfi_pkg::STEP_W-1:0]  step;
		logic                        running;
	} fade_word_t;

	// shadow of the core state
	logic [pfi_pkg::STEP_W-1:0] total_steps;
	logic [pfi_pkg::STEP_W-1:0] step_cnt;
	logic                       fade_on;
	fade_word_t                 expected_words[$];
	int                         fails = 0;

	// count*(to-from)/steps + from, truncating toward zero, low 8 bits kept
	function automatic logic [pfi_pkg::COLOR_W-1:0] blend_channel(
			logic [pfi_pkg::STEP_W-1:0] count, int divisor,
			logic [pfi_pkg::COLOR_W-1:0] a, logic [pfi_pkg::COLOR_W-1:0] b);
		int q;
		q = (int'(count) * (int'(b) - int'(a))) / divisor;
		return pfi_pkg::COLOR_W'(q + int'(a));
	endfunction

	// advance the fade for one entry and build the word it should produce
	function automatic fade_word_t fade_entry(logic [1:0] op,
			logic [pfi_pkg::COLOR_W-1:0] fr, logic [pfi_pkg::COLOR_W-1:0] fg,
			logic [pfi_pkg::COLOR_W-1:0] fb, logic [pfi_pkg::COLOR_W-1:0] tr,
			logic [pfi_pkg::COLOR_W-1:0] tg, logic [pfi_pkg::COLOR_W-1:0] tb,
			logic blk);
		int         divisor;
		fade_word_t w;
		// a step total of zero acts as one
		divisor = (total_steps == '0) ? 1 : int'(total_steps);
		if (blk) begin
			tr = '0;
			tg = '0;
			tb = '0;
		end
		if (op == pfi_pkg::OP_BEGIN) begin
			if (fade_on) begin
				if (step_cnt != pfi_pkg::STEP_MAX)
					step_cnt = step_cnt + 1'b1;
				if (int'(step_cnt) >= divisor)
					fade_on = 1'b0;
			end else begin
				step_cnt = '0;
				fade_on  = 1'b1;
			end
		end else if (op == pfi_pkg::OP_STOP) begin
			fade_on = 1'b0;
		end
		w.red     = blend_channel(step_cnt, divisor, fr, tr);
		w.green   = blend_channel(step_cnt, divisor, fg, tg);
		w.blue    = blend_channel(step_cnt, divisor, fb, tb);
		w.step    = step_cnt;
		w.running = fade_on;
		return w;
	endfunction

	// track config and input words, check output words
	always @(posedge clk or negedge arst_n) begin
		fade_word_t seen;
		fade_word_t want;
		if (!arst_n) begin
			total_steps = pfi_pkg::STEPS_RESET;
			step_cnt    = '0;
			fade_on     = 1'b0;
			expected_words.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				total_steps = cfg_data;
			if (in_valid && !in_stall)
				expected_words.push_back(fade_entry(opcode, from_red, from_green,
					from_blue, to_red, to_green, to_blue, to_black));
			if (out_valid && !out_stall) begin
				seen = {out_red, out_green, out_blue, step_number, fade_running};
				if (expected_words.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: output word with none expected:", $time,
							" r=%0d g=%0d b=%0d", seen.red, seen.green, seen.blue,
							" step=%0d run=%0d", seen.step, seen.running);
				end else begin
					want = expected_words.pop_front();
					if (seen !== want) begin
						fails++;
						if (fails <= 10)
							$display("%0t: word mismatch:", $time,
								" exp r=%0d g=%0d b=%0d", want.red, want.green,
								want.blue, " step=%0d run=%0d,", want.step,
								want.running, " got r=%0d g=%0d b=%0d", seen.red,
								seen.green, seen.blue, " step=%0d run=%0d",
								seen.step, seen.running);
					end
				end
			end
		end
		pending     <= expected_words.size();
		error_count <= fails;
	end

endmodule

@@ test/palette_fade_interpolator_core_test.sv @@
// ----------------------------------------------------------------------------
// Palette fade interpolator testbench
// Drives palette entry words into the fade core under several step totals:
// a directed opening for the corner cases, then fade calls with random
// colors mixed with stray opcodes, with random gaps and stalls on both sides
// and one long output hold-off. The checker beside the core does the
// predicting and comparing; this module gives the verdict.
// ----------------------------------------------------------------------------
module palette_fade_interpolator_core_test;

	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam int         HOLD_CYCLES = 600;
	localparam int         PHASE_WORDS = 200;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [pfi_pkg::STEP_W-1:0]   cfg_data;
	logic                         in_valid;
	logic                         in_stall;
	logic [1:0]                   opcode;
	logic [pfi_pkg::COLOR_W-1:0]  from_red, from_green, from_blue;
	logic [pfi_pkg::COLOR_W-1:0]  to_red, to_green, to_blue;
	logic                         to_black;
	logic                         out_valid;
	logic                         out_stall;
	logic [pfi_pkg::COLOR_W-1:0]  out_red, out_green, out_blue;
	logic [pfi_pkg::STEP_W-1:0]   step_number;
	logic                         fade_running;
	int                           error_count;
	int                           pending;

	// stimulus controls
	bit idle_en = 1'b1;
	bit hold_off = 1'b0;
	int words_sent = 0;

	always #1 clk = ~clk;

	palette_fade_interpolator_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.from_red     (from_red),
		.from_green   (from_green),
		.from_blue    (from_blue),
		.to_red       (to_red),
		.to_green     (to_green),
		.to_blue      (to_blue),
		.to_black     (to_black),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.step_number  (step_number),
		.fade_running (fade_running)
	);

	palette_fade_interpolator_core_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.from_red     (from_red),
		.from_green   (from_green),
		.from_blue    (from_blue),
		.to_red       (to_red),
		.to_green     (to_green),
		.to_blue      (to_blue),
		.to_black     (to_black),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.step_number  (step_number),
		.fade_running (fade_running),
		.error_count  (error_count),
		.pending      (pending)
	);

	// mostly random, with the color extremes often
	function automatic logic [pfi_pkg::COLOR_W-1:0] pick_color();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return pfi_pkg::COLOR_W'($urandom_range(0, 255));
		endcase
	endfunction

	// offer one entry word and hold it until the core takes it
	task automatic send_entry(logic [1:0] op, logic [pfi_pkg::COLOR_W-1:0] fr,
			logic [pfi_pkg::COLOR_W-1:0] fg, logic [pfi_pkg::COLOR_W-1:0] fb,
			logic [pfi_pkg::COLOR_W-1:0] tr, logic [pfi_pkg::COLOR_W-1:0] tg,
			logic [pfi_pkg::COLOR_W-1:0] tb, logic blk);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		from_red   <= fr;
		from_green <= fg;
		from_blue  <= fb;
		to_red     <= tr;
		to_green   <= tg;
		to_blue    <= tb;
		to_black   <= blk;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
	endtask

	task automatic send_random(logic [1:0] op);
		send_entry(op, pick_color(), pick_color(), pick_color(), pick_color(),
			pick_color(), pick_color(), $urandom_range(0, 3) == 0);
	endtask

	// stop offering and wait for every outstanding word to come back
	task automatic wait_palette_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// step total may only change with the core idle
	task automatic set_step_total(logic [pfi_pkg::STEP_W-1:0] total);
		wait_palette_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= total;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// fade calls (begin word plus a pass of continue words) and stray words
	task automatic fade_phase(int n_words, int pass_max);
		int stop_at;
		int pass_len;
		stop_at = words_sent + n_words;
		while (words_sent < stop_at) begin
			if ($urandom_range(0, 9) < 8) begin
				send_random(pfi_pkg::OP_BEGIN);
				pass_len = $urandom_range(1, pass_max);
				for (int k = 0; k < pass_len && words_sent < stop_at; k++)
					send_random(pfi_pkg::OP_CONTINUE);
			end else begin
				send_random(2'($urandom_range(0, 3)));
			end
		end
	endtask

	// output side: random stall bursts, plus one long hold-off on request
	initial begin
		bit held_done;
		held_done = 1'b0;
		forever begin
			if (hold_off && !held_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				held_done = 1'b1;
			end else if (idle_en && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
		end
	end

	// run limit
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// stimulus and verdict
	initial begin
		cfg_valid  <= 1'b0;
		cfg_data   <= '0;
		in_valid   <= 1'b0;
		opcode     <= pfi_pkg::OP_CONTINUE;
		from_red   <= '0;
		from_green <= '0;
		from_blue  <= '0;
		to_red     <= '0;
		to_green   <= '0;
		to_blue    <= '0;
		to_black   <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset step total: start, first step, pass words, black target,
		// unused opcode, stop and restart
		send_entry(pfi_pkg::OP_BEGIN, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 1'b0);
		send_entry(pfi_pkg::OP_BEGIN, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 1'b0);
		send_entry(pfi_pkg::OP_CONTINUE, 8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd128,
			1'b0);
		send_entry(pfi_pkg::OP_CONTINUE, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
			8'd255, 1'b1);
		send_entry(OP_UNUSED, 8'd17, 8'd200, 8'd90, 8'd3, 8'd250, 8'd45, 1'b0);
		send_entry(pfi_pkg::OP_STOP, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 1'b0);
		send_entry(pfi_pkg::OP_CONTINUE, 8'd100, 8'd100, 8'd100, 8'd0, 8'd200, 8'd255,
			1'b0);
		repeat (4) send_entry(pfi_pkg::OP_BEGIN, 8'd255, 8'd0, 8'd77, 8'd0, 8'd255,
			8'd77, 1'b0);

		// one-step fade ends on the second begin
		set_step_total(8'd1);
		repeat (2) send_entry(pfi_pkg::OP_BEGIN, 8'd10, 8'd250, 8'd0, 8'd240, 8'd5,
			8'd255, 1'b0);
		send_entry(pfi_pkg::OP_CONTINUE, 8'd10, 8'd250, 8'd0, 8'd240, 8'd5, 8'd255,
			1'b0);

		// step total of zero behaves as one
		set_step_total(8'd0);
		repeat (2) send_entry(pfi_pkg::OP_BEGIN, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255,
			8'd0, 1'b1);
		send_entry(pfi_pkg::OP_CONTINUE, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255,
			1'b0);

		// step total lowered under the count mid-fade: wrapped colors, then end
		set_step_total(8'd255);
		repeat (6) send_entry(pfi_pkg::OP_BEGIN, 8'd0, 8'd255, 8'd30, 8'd255, 8'd0,
			8'd220, 1'b0);
		set_step_total(8'd2);
		send_entry(pfi_pkg::OP_CONTINUE, 8'd0, 8'd255, 8'd30, 8'd255, 8'd0, 8'd220,
			1'b0);
		send_entry(pfi_pkg::OP_BEGIN, 8'd0, 8'd255, 8'd30, 8'd255, 8'd0, 8'd220, 1'b0);

		// random fade calls under a range of step totals
		set_step_total(8'd1);
		fade_phase(PHASE_WORDS, 4);
		set_step_total(8'd255);
		fade_phase(PHASE_WORDS, 3);
		set_step_total(8'd0);
		fade_phase(PHASE_WORDS, 4);
		set_step_total(pfi_pkg::STEP_W'($urandom_range(2, 8)));
		hold_off = 1'b1;
		fade_phase(PHASE_WORDS, 6);
		set_step_total(pfi_pkg::STEP_W'($urandom_range(9, 40)));
		fade_phase(PHASE_WORDS, 3);
		set_step_total(pfi_pkg::STEP_W'($urandom_range(1, 255)));
		fade_phase(PHASE_WORDS, 3);
		set_step_total(pfi_pkg::STEP_W'($urandom_range(2, 6)));
		fade_phase(PHASE_WORDS, 8);
		set_step_total(pfi_pkg::STEP_W'($urandom_range(2, 16)));
		fade_phase(PHASE_WORDS, 5);

		// closing stretch at full rate
		set_step_total(8'd3);
		idle_en = 1'b0;
		fade_phase(PHASE_WORDS, 4);

		wait_palette_idle();
		repeat (120) @(posedge clk);
		if (error_count == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
